// File: rtl/rlck_pkg.sv
package rlck_pkg;

	// Internal number format: signed Q15.16 in 32 bits
	typedef logic signed [31:0] fix_t;
	// Output factor format: signed Q3.14 in 18 bits
	typedef logic signed [17:0] fac_t;

	// Carried alongside every item: knot radius (Q1.15) and "not the centre knot"
	typedef struct packed {
		logic [15:0] rq;
		logic        nz;
	} tag_t;

	typedef enum logic [3:0] {
		REG_ENABLES    = 4'd0,
		REG_DIST_POLY  = 4'd1,
		REG_DIST_SCALE = 4'd2,
		REG_DIST_GAIN  = 4'd3,
		REG_CA_RED     = 4'd4,
		REG_CA_BLUE    = 4'd5,
		REG_CA_RED_G   = 4'd6,
		REG_CA_BLUE_G  = 4'd7
	} cfg_reg_t;

	localparam int unsigned STAGES = 15;

	localparam fix_t ONE_Q16     = 32'sd65536;
	localparam fix_t NEG_ONE_Q16 = -32'sd65536;
	localparam fix_t FIX_MAX     = 32'sh7fff_ffff;
	localparam fix_t FIX_MIN     = 32'sh8000_0000;
	localparam fac_t FAC_MAX     = 18'sd131071;
	localparam fac_t FAC_MIN     = -18'sd131072;

	// Saturating add
	function automatic fix_t add_q(input fix_t a, input fix_t b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s > 33'sd2147483647) begin
			return FIX_MAX;
		end else if (s < -33'sd2147483648) begin
			return FIX_MIN;
		end
		return fix_t'(s);
	endfunction

	// Product rounded half up to 16 fraction bits, saturated
	function automatic fix_t mul_q(input fix_t a, input fix_t b);
		logic signed [63:0] p;
		logic signed [47:0] q;
		p = 64'(a) * 64'(b);
		p = p + 64'sd32768;
		q = 48'(p >>> 16);
		if (q > 48'sd2147483647) begin
			return FIX_MAX;
		end else if (q < -48'sd2147483648) begin
			return FIX_MIN;
		end
		return fix_t'(q);
	endfunction

	// Signed Q2.14 field to Q15.16
	function automatic fix_t coef_q(input logic [15:0] f);
		return fix_t'({{14{f[15]}}, f, 2'b00});
	endfunction

	// Unsigned Q2.14 to Q15.16
	function automatic fix_t uq_q(input logic [15:0] f);
		return fix_t'({14'd0, f, 2'b00});
	endfunction

	// Q15.16 to Q3.14, round half up, saturate
	function automatic fac_t out_q(input fix_t v);
		logic signed [32:0] w;
		logic signed [30:0] q;
		w = 33'(v) + 33'sd2;
		q = 31'(w >>> 2);
		if (q > 31'sd131071) begin
			return FAC_MAX;
		end else if (q < -31'sd131072) begin
			return FAC_MIN;
		end
		return fac_t'(q);
	endfunction

endpackage

// File: rtl/radial_lens_correction_knots.sv
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid/s_tready  | s_tdata[3:0] knot_index
// m_      | out | m_tvalid/m_tready  | m_tdata: radius, red, green, blue factors
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// One item per cycle sustained while m_tready is high; m_tvalid is the last stage's valid.
// The depth is set by the chain of 13 dependent Q15.16 multiplies (one per stage,
// red and blue lanes side by side from stage 11).
// Reset clears the valid bits and loads the register reset values; no clearing pass.
// Stalls: each stage holds when it is full and the stage after it cannot take;
// empty stages keep filling, so up to 15 items queue behind a stalled output.
module radial_lens_correction_knots #(
	parameter int KNOT_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [47:0] cfg_data,
	// input items: tdata = {4'b0, knot_index[3:0]}
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// results: tdata low to high = knot_radius[15:0], red_factor[33:16],
	// green_factor[51:34], blue_factor[69:52], zero pad[71:70]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata
);
	import rlck_pkg::*;

	localparam int DEN = KNOT_COUNT - 1;

	// ---------------- configuration registers ----------------
	logic [1:0]  enables_q;
	logic [47:0] poly_q;
	logic [15:0] scale_q;
	logic [15:0] gain_q;
	logic [47:0] cred_q;
	logic [47:0] cblue_q;
	logic [15:0] gred_q;
	logic [15:0] gblue_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enables_q <= 2'd0;
			poly_q    <= 48'd0;
			scale_q   <= 16'd16384;
			gain_q    <= 16'd16384;
			cred_q    <= 48'd0;
			cblue_q   <= 48'd0;
			gred_q    <= 16'd16384;
			gblue_q   <= 16'd16384;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ENABLES:    enables_q <= cfg_data[1:0];
				REG_DIST_POLY:  poly_q    <= cfg_data;
				REG_DIST_SCALE: scale_q   <= cfg_data[15:0];
				REG_DIST_GAIN:  gain_q    <= cfg_data[15:0];
				REG_CA_RED:     cred_q    <= cfg_data;
				REG_CA_BLUE:    cblue_q   <= cfg_data;
				REG_CA_RED_G:   gred_q    <= cfg_data[15:0];
				REG_CA_BLUE_G:  gblue_q   <= cfg_data[15:0];
				default: ;  // unknown register, ignored
			endcase
		end
	end

	fix_t s_fx, one_m;
	assign s_fx = uq_q(scale_q);

	// ---------------- knot radius table ----------------
	// index clamped to DEN, radius rounded half up
	logic [15:0] rq_tab [16];
	generate
		for (genvar g = 0; g < 16; g++) begin : g_rq
			localparam int EFF = (g > DEN) ? DEN : g;
			localparam int RQ  = (EFF * 65536 + DEN) / (2 * DEN);
			assign rq_tab[g] = 16'(RQ);
		end
	endgenerate

	// ---------------- flow control ----------------
	logic [STAGES:1] vld_q;
	logic [STAGES:1] adv;

	always_comb begin
		adv[STAGES] = !vld_q[STAGES] || m_tready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign s_tready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// radius and centre flag ride along every stage
	tag_t tag_q [STAGES:1];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			tag_q[1].rq <= rq_tab[s_tdata[3:0]];
			tag_q[1].nz <= (s_tdata[3:0] != 4'd0);
		end
		for (int k = 2; k <= STAGES; k++) begin
			if (adv[k]) begin
				tag_q[k] <= tag_q[k-1];
			end
		end
	end

	// ---------------- datapath ----------------
	fix_t r_s1, r_s8;
	assign r_s1 = fix_t'({15'd0, tag_q[1].rq, 1'b0});
	assign r_s8 = fix_t'({15'd0, tag_q[8].rq, 1'b0});
	assign one_m = ONE_Q16;

	fix_t rs_s2;
	fix_t t_s3, t_s4, t_s5;
	fix_t m_s4, m_s5, m_s6;
	fix_t h_s7, m_s8;
	fix_t base_s9, base_s10, base_s11, base_s12, base_s13, base_s14;
	fix_t rd_s9, d_s10, d_s11;
	fix_t mr_s11, mb_s11, mr_s12, mb_s12;
	fix_t pr_s13, pb_s13, gr_s14, gb_s14;
	fac_t red_s15, green_s15, blue_s15;
	fix_t base_sel;

	// distortion polynomial, Horner form in t = (r*s)^2
	always_ff @(posedge clk) begin
		if (adv[2]) rs_s2 <= mul_q(r_s1, s_fx);
		if (adv[3]) t_s3  <= mul_q(rs_s2, rs_s2);
		if (adv[4]) begin
			m_s4 <= mul_q(t_s3, coef_q(poly_q[47:32]));
			t_s4 <= t_s3;
		end
		if (adv[5]) begin
			m_s5 <= mul_q(t_s4, add_q(coef_q(poly_q[31:16]), m_s4));
			t_s5 <= t_s4;
		end
		if (adv[6]) m_s6 <= mul_q(t_s5, add_q(coef_q(poly_q[15:0]), m_s5));
		if (adv[7]) h_s7 <= mul_q(s_fx, add_q(one_m, m_s6));
		if (adv[8]) m_s8 <= mul_q(coef_q(gain_q), add_q(h_s7, NEG_ONE_Q16));
	end

	assign base_sel = enables_q[0] ? add_q(m_s8, ONE_Q16) : ONE_Q16;

	// lateral CA: d = (base*r)^2, then c0 + d*(c2 + d*c4) per color
	always_ff @(posedge clk) begin
		if (adv[9]) begin
			base_s9 <= base_sel;
			rd_s9   <= mul_q(base_sel, r_s8);
		end
		if (adv[10]) begin
			d_s10    <= mul_q(rd_s9, rd_s9);
			base_s10 <= base_s9;
		end
		if (adv[11]) begin
			mr_s11   <= mul_q(d_s10, coef_q(cred_q[47:32]));
			mb_s11   <= mul_q(d_s10, coef_q(cblue_q[47:32]));
			d_s11    <= d_s10;
			base_s11 <= base_s10;
		end
		if (adv[12]) begin
			mr_s12   <= mul_q(d_s11, add_q(coef_q(cred_q[31:16]), mr_s11));
			mb_s12   <= mul_q(d_s11, add_q(coef_q(cblue_q[31:16]), mb_s11));
			base_s12 <= base_s11;
		end
		if (adv[13]) begin
			pr_s13   <= mul_q(base_s12, add_q(coef_q(cred_q[15:0]), mr_s12));
			pb_s13   <= mul_q(base_s12, add_q(coef_q(cblue_q[15:0]), mb_s12));
			base_s13 <= base_s12;
		end
		if (adv[14]) begin
			gr_s14   <= mul_q(coef_q(gred_q), pr_s13);
			gb_s14   <= mul_q(coef_q(gblue_q), pb_s13);
			base_s14 <= base_s13;
		end
		if (adv[15]) begin
			green_s15 <= out_q(base_s14);
			if (enables_q[1] && tag_q[14].nz) begin
				red_s15  <= out_q(add_q(base_s14, gr_s14));
				blue_s15 <= out_q(add_q(base_s14, gb_s14));
			end else begin
				red_s15  <= out_q(base_s14);
				blue_s15 <= out_q(base_s14);
			end
		end
	end

	assign m_tvalid = vld_q[STAGES];
	assign m_tdata  = {2'b00, blue_s15, green_s15, red_s15, tag_q[STAGES].rq};

	// ---------------- assertions ----------------
	// input side only backs up once every stage holds an item
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_q == '1))
		else $error("input stalled with an empty stage");

	// without distortion the green factor is exactly 1.0
	a_green_unity: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !enables_q[0]) |-> (m_tdata[51:34] == 18'd16384))
		else $error("green factor not unity with distortion off");

	// without CA correction all three colors agree
	a_colors_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !enables_q[1]) |->
			(m_tdata[33:16] == m_tdata[51:34] && m_tdata[69:52] == m_tdata[51:34]))
		else $error("color factors differ with CA off");

endmodule
